FILE: sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the hall speed estimator and its filter.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  // Field widths
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned SPEED_W   = 31;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PP_W      = 8;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // freq * 60 fits in 30 bits
  localparam int unsigned DIVIDEND_W = 30;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Stream packing
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 120;
  localparam int unsigned M_TUSER_W = 1;

  // Reset values of the configuration registers
  localparam logic [PP_W-1:0]    PP_RESET      = 8'd4;
  localparam logic [WORD_W-1:0]  TIMEOUT_RESET = 32'd24000000;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 4'd4;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLE_PAIRS = 2'd0,
    REG_DIR_INV    = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_SHIFT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PP_W-1:0]    pairs;
    logic               dir_invert;
    logic [WORD_W-1:0]  age_limit;
    logic [SHIFT_W-1:0] filter_shift;
  } cfg_t;

  // Request into the serial divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PP_W-1:0]       divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: sv/hall_speed_estimator_filter_top.sv
// ----------------------------------------------------------------------------
// hall_speed_estimator_filter_top
// Hall sample qualification, speed = freq*60/pole pairs through a serial
// divider, and a first-order exponential filter on the result.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata: direction, frequency, age, counter
//           |           | tuser: present, valid
//  m_axis   | out       | tdata: raw, filtered, frequency, direction, count
//           |           | tuser: speed_valid
//  cfg      | in        | index + 32-bit write data, ready out of reset
//
// An accepted sample goes through the divider steps and done, then error,
// filter, commit and idle up to the next input transfer; a rejected sample
// goes straight to commit and idle. s_axis_tready is high only while idle
// and out of reset, so a sample is taken while a result still waits on
// m_axis; commit then waits until that result is taken. Synchronous reset
// clears all estimator state to zero and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_speed_estimator_filter_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // sample stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] hall_direction, [25:2] electrical_frequency,
  // [57:26] sample_age_cycles, [89:58] update_counter, [95:90] zero
  input  wire logic [hse_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] sample_present, [1] sample_valid
  input  wire logic [hse_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [30:0] raw_speed, [61:31] filtered_speed, [85:62] frequency_echo,
  // [87:86] output direction, [119:88] measurement_count
  output logic [hse_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // [0] speed_valid
  output logic [hse_pkg::M_TUSER_W-1:0]       m_axis_tuser,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hse_pkg::WORD_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_ERR  = 5'b00100,
    ST_FILT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  hse_pkg::cfg_t     cfg;
  hse_pkg::div_req_t div_req;
  logic              div_done;
  logic [hse_pkg::DIVIDEND_W-1:0] div_quo;

  // input field decode
  logic [hse_pkg::DIR_W-1:0]  in_dir;
  logic [hse_pkg::FREQ_W-1:0] in_freq;
  logic [hse_pkg::WORD_W-1:0] in_age;
  logic [hse_pkg::WORD_W-1:0] in_counter;
  logic                       in_reject;
  logic                       in_accept;

  // latched sample
  logic                       rej_q;
  logic                       neg_q;
  logic [hse_pkg::FREQ_W-1:0] freq_q;
  logic [hse_pkg::WORD_W-1:0] counter_q;

  // working values
  logic signed [hse_pkg::SPEED_W-1:0] raw_new;
  logic signed [hse_pkg::SPEED_W-1:0] filt_new;
  logic signed [hse_pkg::WORD_W-1:0]  err;
  logic [hse_pkg::WORD_W-1:0]         err_mag;
  logic [hse_pkg::WORD_W-1:0]         err_shr;
  logic signed [hse_pkg::WORD_W-1:0]  step;
  logic signed [hse_pkg::WORD_W-1:0]  filt_sum;
  logic [hse_pkg::DIR_W-1:0]          ldir;
  logic                               reload;
  logic                               fresh;
  logic                               out_free;
  logic                               commit;

  // estimator state, also the result payload
  logic signed [hse_pkg::SPEED_W-1:0] raw_reg;
  logic signed [hse_pkg::SPEED_W-1:0] filt_reg;
  logic [hse_pkg::FREQ_W-1:0]         freq_reg;
  logic [hse_pkg::DIR_W-1:0]          dir_reg;
  logic                               valid_reg;
  logic [hse_pkg::WORD_W-1:0]         count_reg;
  logic [hse_pkg::WORD_W-1:0]         last_counter_reg;

  hse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sample qualification
  assign in_dir     = s_axis_tdata[1:0];
  assign in_freq    = s_axis_tdata[25:2];
  assign in_age     = s_axis_tdata[57:26];
  assign in_counter = s_axis_tdata[89:58];
  assign in_reject  = !s_axis_tuser[0] || !s_axis_tuser[1] ||
                      (in_dir == hse_pkg::DIR_NONE) || (in_freq == '0) ||
                      (in_age > cfg.age_limit);

  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // divider launch: freq*60 = freq*64 - freq*4, pole pairs of zero act as one
  assign div_req.start    = in_accept && !in_reject;
  assign div_req.dividend = ({in_freq, 6'b0} - {4'b0, in_freq, 2'b0});
  assign div_req.divisor  = (cfg.pairs == '0) ? hse_pkg::PP_W'(1)
                                              : cfg.pairs;

  // direction after inversion, and filter decisions
  assign ldir   = neg_q ? hse_pkg::DIR_REV : hse_pkg::DIR_FWD;
  assign reload = !valid_reg || (dir_reg != ldir);
  assign fresh  = (counter_q != last_counter_reg);

  // filter step: |err| >> shift, sign restored, so truncation is toward zero
  assign err_mag  = err[hse_pkg::WORD_W-1] ? hse_pkg::WORD_W'(-err)
                                           : hse_pkg::WORD_W'(err);
  assign err_shr  = err_mag >> cfg.filter_shift;
  assign step     = err[hse_pkg::WORD_W-1] ? -$signed(err_shr) : $signed(err_shr);
  assign filt_sum = {filt_reg[hse_pkg::SPEED_W-1], filt_reg} + step;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign commit   = (state == ST_DONE) && out_free;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = in_reject ? ST_DONE : ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_ERR;
      ST_ERR:  state_next = ST_FILT;
      ST_FILT: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sample latch and working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rej_q     <= in_reject;
      neg_q     <= in_dir[1] ^ cfg.dir_invert;
      freq_q    <= in_freq;
      counter_q <= in_counter;
    end
    if (state == ST_DIV && div_done) begin
      raw_new <= neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
    if (state == ST_ERR) begin
      err <= {raw_new[hse_pkg::SPEED_W-1], raw_new} -
             {filt_reg[hse_pkg::SPEED_W-1], filt_reg};
    end
    if (state == ST_FILT) begin
      if (reload) begin
        filt_new <= raw_new;
      end else if (fresh) begin
        filt_new <= filt_sum[hse_pkg::SPEED_W-1:0];
      end else begin
        filt_new <= filt_reg;
      end
    end
  end

  // commit of the estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_reg          <= '0;
      filt_reg         <= '0;
      freq_reg         <= '0;
      dir_reg          <= hse_pkg::DIR_NONE;
      valid_reg        <= 1'b0;
      count_reg        <= '0;
      last_counter_reg <= '0;
    end else if (commit) begin
      if (rej_q) begin
        raw_reg   <= '0;
        filt_reg  <= '0;
        freq_reg  <= '0;
        dir_reg   <= hse_pkg::DIR_NONE;
        valid_reg <= 1'b0;
      end else begin
        raw_reg   <= raw_new;
        filt_reg  <= filt_new;
        freq_reg  <= freq_q;
        dir_reg   <= ldir;
        valid_reg <= 1'b1;
        if (fresh) begin
          count_reg        <= count_reg + 1'b1;
          last_counter_reg <= counter_q;
        end
      end
    end
  end

  // result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {count_reg, dir_reg, freq_reg, filt_reg, raw_reg};
  assign m_axis_tuser = valid_reg;

`ifndef SYNTHESIS
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count_reg == $past(count_reg)) ||
             (count_reg == $past(count_reg) + 32'd1))
    else $error("measurement count moved by more than one");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    !valid_reg |-> (raw_reg == '0) && (filt_reg == '0) && (freq_reg == '0) &&
                   (dir_reg == hse_pkg::DIR_NONE))
    else $error("speed outputs not cleared while invalid");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire

FILE: sv/hse_cfg_regs.sv
// ----------------------------------------------------------------------------
// hse_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hse_pkg::WORD_W-1:0]     cfg_data,
  output hse_pkg::cfg_t                       cfg
);

  // able to take a write whenever out of reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pairs        <= hse_pkg::PP_RESET;
      cfg.dir_invert   <= 1'b0;
      cfg.age_limit    <= hse_pkg::TIMEOUT_RESET;
      cfg.filter_shift <= hse_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (hse_pkg::cfg_reg_t'(cfg_index))
        hse_pkg::REG_POLE_PAIRS: cfg.pairs <= cfg_data[hse_pkg::PP_W-1:0];
        hse_pkg::REG_DIR_INV:    cfg.dir_invert <= cfg_data[0];
        hse_pkg::REG_TIMEOUT:    cfg.age_limit <= cfg_data;
        hse_pkg::REG_SHIFT:      cfg.filter_shift <= cfg_data[hse_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/hse_div.sv
// ----------------------------------------------------------------------------
// hse_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hse_pkg::div_req_t                req,
  output logic                                  done,
  output logic [hse_pkg::DIVIDEND_W-1:0]        quotient
);

  localparam logic [hse_pkg::DIV_CNT_W-1:0] LAST_STEP =
    hse_pkg::DIV_CNT_W'(hse_pkg::DIVIDEND_W - 1);

  logic                            busy;
  logic [hse_pkg::DIV_CNT_W-1:0]   cnt;
  logic [hse_pkg::PP_W-1:0]        divisor;
  logic [hse_pkg::PP_W-1:0]        rem;
  logic [hse_pkg::PP_W:0]          trial;
  logic                            fits;

  // shift in next dividend bit and try the subtraction
  assign trial = {rem, quotient[hse_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[hse_pkg::DIVIDEND_W-2:0], fits};
      rem      <= fits ? hse_pkg::PP_W'(trial - {1'b0, divisor})
                       : trial[hse_pkg::PP_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: bench/hall_speed_estimator_filter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hall_speed_estimator_filter_top_test
// Self-checking bench for the hall speed estimator. Hall samples go in on the
// sample stream, and an in-bench estimator works out the speed record that
// each transfer should give. Results are compared field by field in order.
// A short directed part comes first. Random traffic follows under several
// register settings and idle patterns, then a long receiver hold-off.
// ----------------------------------------------------------------------------
module hall_speed_estimator_filter_top_test;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned SAMPLE_BITS  =
    hse_pkg::DIR_W + hse_pkg::FREQ_W + 2 * hse_pkg::WORD_W;
  // second encoding of reverse: any negative code means -1
  localparam logic [hse_pkg::DIR_W-1:0] DIR_REV_ALT = 2'b10;

  // Same bit order as {s_axis_tuser, s_axis_tdata[89:0]}
  typedef struct packed {
    logic                       valid;
    logic                       present;
    logic [hse_pkg::WORD_W-1:0] counter;
    logic [hse_pkg::WORD_W-1:0] age;
    logic [hse_pkg::FREQ_W-1:0] frequency;
    logic [hse_pkg::DIR_W-1:0]  direction;
  } hall_sample_t;

  // Same bit order as {m_axis_tuser, m_axis_tdata}
  typedef struct packed {
    logic                        speed_valid;
    logic [hse_pkg::WORD_W-1:0]  count;
    logic [hse_pkg::DIR_W-1:0]   direction;
    logic [hse_pkg::FREQ_W-1:0]  frequency;
    logic [hse_pkg::SPEED_W-1:0] filtered;
    logic [hse_pkg::SPEED_W-1:0] raw;
  } speed_result_t;

  // DUT signals; the bench-driven inputs are known from time zero
  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hse_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [hse_pkg::S_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hse_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic [hse_pkg::M_TUSER_W-1:0]   m_axis_tuser;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [hse_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [hse_pkg::WORD_W-1:0]      cfg_data      = '0;

  // Estimator copy: registers and state
  logic [hse_pkg::PP_W-1:0]    pairs_q        = hse_pkg::PP_RESET;
  logic                        inverted_q     = 1'b0;
  logic [hse_pkg::WORD_W-1:0]  timeout_q      = hse_pkg::TIMEOUT_RESET;
  logic [hse_pkg::SHIFT_W-1:0] shift_q        = hse_pkg::SHIFT_RESET;
  longint                      raw_q          = 0;
  longint                      filt_q         = 0;
  int                          dir_q          = 0;
  bit                          valid_q        = 1'b0;
  logic [hse_pkg::WORD_W-1:0]  count_q        = '0;
  logic [hse_pkg::WORD_W-1:0]  last_counter_q = '0;

  speed_result_t expected_speeds[$];

  // Idle control and random sequence state
  int unsigned                send_idle_pct   = 0;
  int unsigned                recv_stall_pct  = 0;
  int unsigned                hold_off_cycles = 0;
  logic [hse_pkg::DIR_W-1:0]  run_dir         = hse_pkg::DIR_FWD;
  logic [hse_pkg::WORD_W-1:0] run_counter     = '0;
  logic [hse_pkg::FREQ_W-1:0] run_freq        = 24'd50000;

  // Statistics
  int unsigned mismatches = 0;
  int unsigned n_accepted = 0;
  int unsigned n_rejected = 0;
  int unsigned n_reloads  = 0;
  int unsigned n_steps    = 0;
  int unsigned n_writes   = 0;
  int unsigned cycle_count = 0;

  hall_speed_estimator_filter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected speed record for one sample; advances the estimator copy
  function automatic speed_result_t estimate_speed(input hall_sample_t s);
    speed_result_t     r;
    int                sdir;
    int                ldir;
    int unsigned       divisor;
    longint unsigned   mag;
    longint unsigned   emag;
    longint            raw;
    longint            err;
    longint            step;
    bit                fresh;
    sdir = (s.direction == hse_pkg::DIR_NONE) ? 0 :
           (s.direction == hse_pkg::DIR_FWD) ? 1 : -1;
    if (!s.present || !s.valid || sdir == 0 || s.frequency == '0 ||
        s.age > timeout_q) begin
      raw_q   = 0;
      filt_q  = 0;
      dir_q   = 0;
      valid_q = 1'b0;
      n_rejected++;
    end else begin
      divisor = (pairs_q == '0) ? 1 : pairs_q;
      mag     = (longint'(s.frequency) * SEC_PER_MIN) / divisor;
      ldir    = inverted_q ? -sdir : sdir;
      raw     = (ldir > 0) ? $signed(mag) : -$signed(mag);
      fresh   = (s.counter != last_counter_q);
      // reload on first good sample or a change of direction
      if (!valid_q || dir_q != ldir) begin
        filt_q = raw;
        n_reloads++;
      end else if (fresh) begin
        // error scaled down, truncated towards zero
        err  = raw - filt_q;
        emag = (err < 0) ? -err : err;
        step = $signed(emag >> shift_q);
        if (err < 0) step = -step;
        filt_q = filt_q + step;
        n_steps++;
      end
      raw_q   = raw;
      dir_q   = ldir;
      valid_q = 1'b1;
      if (fresh) begin
        count_q        = count_q + 1'b1;
        last_counter_q = s.counter;
      end
      n_accepted++;
    end
    r.raw         = raw_q[hse_pkg::SPEED_W-1:0];
    r.filtered    = filt_q[hse_pkg::SPEED_W-1:0];
    r.frequency   = valid_q ? s.frequency : '0;
    r.direction   = (dir_q > 0) ? hse_pkg::DIR_FWD :
                    (dir_q < 0) ? hse_pkg::DIR_REV : hse_pkg::DIR_NONE;
    r.count       = count_q;
    r.speed_valid = valid_q;
    return r;
  endfunction

  function automatic hall_sample_t mk_sample(input logic p, input logic v,
                                             input logic [hse_pkg::DIR_W-1:0] d,
                                             input logic [hse_pkg::FREQ_W-1:0] f,
                                             input logic [hse_pkg::WORD_W-1:0] a,
                                             input logic [hse_pkg::WORD_W-1:0] c);
    hall_sample_t s;
    s.present   = p;
    s.valid     = v;
    s.direction = d;
    s.frequency = f;
    s.age       = a;
    s.counter   = c;
    return s;
  endfunction

  // Mostly well-formed runs with random content, the rest noise
  function automatic hall_sample_t random_sample();
    hall_sample_t               s;
    logic [hse_pkg::WORD_W-1:0] near_age;
    near_age = (timeout_q < 1000) ? timeout_q : 32'd1000;
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(2))
          0:       run_dir = hse_pkg::DIR_FWD;
          1:       run_dir = hse_pkg::DIR_REV;
          default: run_dir = DIR_REV_ALT;
        endcase
      end
      case ($urandom_range(9))
        0:       run_counter = $urandom();
        1, 2:    ;  // counter unchanged: filter holds
        default: run_counter = run_counter + 1'b1;
      endcase
      if ($urandom_range(4) == 0) begin
        run_freq = hse_pkg::FREQ_W'($urandom_range(24'hFFFFFF, 1));
      end
      s.present   = 1'b1;
      s.valid     = 1'b1;
      s.direction = run_dir;
      s.counter   = run_counter;
      s.frequency = run_freq ^ hse_pkg::FREQ_W'($urandom_range(255));
      if (s.frequency == '0) s.frequency = hse_pkg::FREQ_W'(1);
      case ($urandom_range(9))
        0:       s.age = timeout_q;
        1, 2:    s.age = $urandom_range(timeout_q);
        default: s.age = $urandom_range(near_age);
      endcase
    end else begin
      s.present   = 1'($urandom_range(1));
      s.valid     = 1'($urandom_range(1));
      s.direction = hse_pkg::DIR_W'($urandom_range(3));
      s.frequency = ($urandom_range(3) == 0) ? '0 : hse_pkg::FREQ_W'($urandom());
      s.age       = $urandom_range(1) ? $urandom() : timeout_q + 1'b1;
      s.counter   = $urandom_range(1) ? $urandom() : run_counter;
    end
    return s;
  endfunction

  // Sample stream driver: one transfer, with random idle cycles first
  task automatic send_sample(input hall_sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, s.counter, s.age, s.frequency, s.direction};
    s_axis_tuser  <= {s.valid, s.present};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_speeds.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input hse_pkg::cfg_reg_t idx,
                           input logic [hse_pkg::WORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [hse_pkg::PP_W-1:0] pp, input logic inv,
                                input logic [hse_pkg::WORD_W-1:0] tmo,
                                input logic [hse_pkg::SHIFT_W-1:0] shift);
    wait_idle();
    write_reg(hse_pkg::REG_POLE_PAIRS, hse_pkg::WORD_W'(pp));
    write_reg(hse_pkg::REG_DIR_INV, hse_pkg::WORD_W'(inv));
    write_reg(hse_pkg::REG_TIMEOUT, tmo);
    write_reg(hse_pkg::REG_SHIFT, hse_pkg::WORD_W'(shift));
  endtask

  // Rejection causes, filter reload and hold, timeout boundary, at reset values
  task automatic test_rejects_and_reload();
    send_sample(mk_sample(1'b0, 1'b1, hse_pkg::DIR_FWD, 24'd1000, 32'd0, 32'd1));
    send_sample(mk_sample(1'b1, 1'b0, hse_pkg::DIR_FWD, 24'd1000, 32'd0, 32'd1));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_NONE, 24'd1000, 32'd0, 32'd1));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd0, 32'd0, 32'd1));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd1000, 32'd0, 32'd1));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd5000, 32'd10, 32'd1));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd5000, 32'd20, 32'd2));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd5000,
                          hse_pkg::TIMEOUT_RESET, 32'd3));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd5000,
                          hse_pkg::TIMEOUT_RESET + 1'b1, 32'd4));
    send_sample(mk_sample(1'b1, 1'b1, DIR_REV_ALT, 24'hFFFFFF, 32'd0, 32'd4));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'hFFFFFF, 32'd0,
                          32'hFFFFFFFF));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_REV, 24'd1, 32'hFFFFFFFF, 32'd0));
  endtask

  // Register extremes: zero and maximum pole pairs, widest and narrowest shift
  task automatic test_register_extremes();
    apply_settings(8'd0, 1'b1, 32'hFFFFFFFF, 4'd15);
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'hFFFFFF, 32'hFFFFFFFF,
                          32'd100));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd1, 32'd0, 32'd101));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_REV, 24'h800000, 32'h80000000,
                          32'd102));
    apply_settings(8'd255, 1'b0, 32'd1, 4'd0);
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'hFFFFFF, 32'd1, 32'd200));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'h123456, 32'd0, 32'd201));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_FWD, 24'd5, 32'd2, 32'd202));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_REV, 24'hAAAAAA, 32'd0, 32'd203));
    send_sample(mk_sample(1'b1, 1'b1, hse_pkg::DIR_REV, 24'h555555, 32'd1, 32'd203));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_items,
                                     input logic [hse_pkg::PP_W-1:0] pp,
                                     input logic inv,
                                     input logic [hse_pkg::WORD_W-1:0] tmo,
                                     input logic [hse_pkg::SHIFT_W-1:0] shift);
    apply_settings(pp, inv, tmo, shift);
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_sample(random_sample());
  endtask

  // Receiver held off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    apply_settings(8'd7, 1'b1, 32'd5000, 4'd2);
    @(posedge clk);
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 400;
    repeat (50) send_sample(random_sample());
  endtask

  // Result stream ready: long hold-off first, else random stalls
  always @(negedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles = hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Transfer monitor: check results, predict accepted samples, track writes
  always @(posedge clk) begin : monitor
    speed_result_t got;
    speed_result_t want;
    hall_sample_t  taken;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_speeds.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result transfer: %h", got);
        end else begin
          want = expected_speeds.pop_front();
          if (got.raw !== want.raw || got.filtered !== want.filtered ||
              got.frequency !== want.frequency || got.direction !== want.direction ||
              got.count !== want.count || got.speed_valid !== want.speed_valid) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"result error (exp/act): raw %0d/%0d filt %0d/%0d ",
                        "freq %0d/%0d dir %b/%b count %0d/%0d valid %b/%b"},
                       $signed(want.raw), $signed(got.raw),
                       $signed(want.filtered), $signed(got.filtered),
                       want.frequency, got.frequency, want.direction, got.direction,
                       want.count, got.count, want.speed_valid, got.speed_valid);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken = {s_axis_tuser, s_axis_tdata[SAMPLE_BITS-1:0]};
        expected_speeds.push_back(estimate_speed(taken));
      end
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          hse_pkg::REG_POLE_PAIRS: pairs_q    = cfg_data[hse_pkg::PP_W-1:0];
          hse_pkg::REG_DIR_INV:    inverted_q = cfg_data[0];
          hse_pkg::REG_TIMEOUT:    timeout_q  = cfg_data;
          hse_pkg::REG_SHIFT:      shift_q    = cfg_data[hse_pkg::SHIFT_W-1:0];
          default:                 ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit, %0d results outstanding",
               expected_speeds.size());
      $display("hall_speed_estimator_filter_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_rejects_and_reload();
    test_register_extremes();
    test_random_traffic(0, 0, 270, hse_pkg::PP_RESET, 1'b0, hse_pkg::TIMEOUT_RESET,
                        hse_pkg::SHIFT_RESET);
    test_random_traffic(62, 0, 270, 8'd255, 1'b1, 32'hFFFFFFFF, 4'd0);
    test_random_traffic(0, 62, 270, 8'd1, 1'b0, 32'd1000, 4'd15);
    test_random_traffic(34, 34, 270, hse_pkg::PP_W'($urandom_range(255)), 1'b1,
                        $urandom_range(32'hFFFFFFFF, 1000),
                        hse_pkg::SHIFT_W'($urandom_range(15)));
    test_backpressure();

    // drain
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples: %0d accepted, %0d rejected, %0d register writes",
             n_accepted + n_rejected, n_accepted, n_rejected, n_writes);
    $display("filter reloads %0d, filter steps %0d, result errors %0d",
             n_reloads, n_steps, mismatches);
    if (mismatches == 0) begin
      $display("hall_speed_estimator_filter_top: match");
    end else begin
      $display("hall_speed_estimator_filter_top: mismatch");
    end
    $finish;
  end

endmodule
